// ===== hdl/rse_pkg.sv =====
// shared widths, codes and types of the rpn stack evaluator
package rse_pkg;

    // field widths
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int DEPTH_W  = 7;
    localparam int STATUS_W = 2;

    // default number of stack entries
    localparam int STACK_DEPTH_DEF = 64;

    // step counter width of the bit-serial divider
    localparam int DIV_CNT_W = $clog2(DATA_W);

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd3;

    // per-cell move control: load from the cell above or the cell below
    typedef struct packed {
        logic load_up;
        logic load_down;
    } cell_ctrl_t;

endpackage

// ===== hdl/rse_cell.sv =====
// one stack entry of the cell chain
module rse_cell (
    input  logic                        aclk,
    input  rse_pkg::cell_ctrl_t         ctrl,
    input  logic [rse_pkg::DATA_W-1:0]  up_data,
    input  logic [rse_pkg::DATA_W-1:0]  down_data,
    output logic [rse_pkg::DATA_W-1:0]  data
);

    logic [rse_pkg::DATA_W-1:0] data_reg;

    // push moves entries down, pop moves them up
    always_ff @(posedge aclk) begin
        if (ctrl.load_up) begin
            data_reg <= up_data;
        end else if (ctrl.load_down) begin
            data_reg <= down_data;
        end
    end

    assign data = data_reg;

endmodule

// ===== hdl/rse_div.sv =====
// bit-serial signed divider, truncating toward zero, one quotient bit per cycle
module rse_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rse_pkg::DATA_W-1:0]  dividend,
    input  logic [rse_pkg::DATA_W-1:0]  divisor,
    output logic [rse_pkg::DATA_W-1:0]  quotient,
    output logic                        done
);

    localparam int W = rse_pkg::DATA_W;

    logic                          busy_reg;
    logic                          done_reg;
    logic [rse_pkg::DIV_CNT_W-1:0] step_reg;
    logic [W-1:0]                  rem_reg;
    logic [W-1:0]                  quo_reg;
    logic [W-1:0]                  den_reg;
    logic                          neg_reg;

    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         ge;

    // restoring step: shift in the next dividend bit and try to subtract
    always_comb begin
        shifted = {rem_reg, quo_reg[W-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = ~diff[W];
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == '1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, operands held as magnitudes
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend[W-1] ? (W'(0) - dividend) : dividend;
            den_reg <= divisor[W-1] ? (W'(0) - divisor) : divisor;
            neg_reg <= dividend[W-1] ^ divisor[W-1];
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;
    assign done     = done_reg;

endmodule

// ===== hdl/rpn_stack_evaluator_core.sv =====
// top level of the rpn stack evaluator: control, alu and the stack cell chain
//
//  channel  | direction | tdata                                  | tuser
//  ---------+-----------+----------------------------------------+-------------
//  s_       | in        | value[31:0]                            | command[2:0]
//  m_       | out       | top_value[31:0] depth[38:32] st[40:39] | -
//
// one token at a time: push, add, subtract, errors and unused codes run from
// transfer in through exec and result; multiply adds a registered-product state,
// divide a state waiting on the bit-serial divider (one quotient bit per cycle).
// synchronous active-low reset empties the stack; entries are not cleared.
// a result waits in the output register while the next token is taken in.
module rpn_stack_evaluator_core #(
    parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [7:0]  s_tuser,   // command[2:0], zero above
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // top_value[31:0], depth[38:32], status[40:39]
);

    localparam int W     = rse_pkg::DATA_W;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]                       state_reg, state_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [rse_pkg::CMD_W-1:0]        cmd_reg;
    logic [W-1:0]                     value_reg;
    logic [rse_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [W-1:0]                     mul_reg, mul_next;

    logic                             m_tvalid_reg;
    logic [W-1:0]                     m_top_reg;
    logic [rse_pkg::DEPTH_W-1:0]      m_depth_reg;
    logic [rse_pkg::STATUS_W-1:0]     m_status_reg;

    logic [W-1:0]                     cell_data [STACK_DEPTH];
    rse_pkg::cell_ctrl_t              ctrl_top;
    rse_pkg::cell_ctrl_t              ctrl_rest;
    logic [W-1:0]                     top_in;
    logic                             apply_pop;

    logic                             div_start;
    logic [W-1:0]                     div_quot;
    logic                             div_done;

    logic                             few;
    logic                             full;
    logic                             out_free;
    logic [CNT_W+rse_pkg::DEPTH_W-1:0] count_ext;

    assign s_tready = (state_reg == S_IDLE);
    assign few      = (count_reg < CNT_W'(2));
    assign full     = (count_reg == CNT_W'(STACK_DEPTH));
    assign out_free = ~m_tvalid_reg | m_tready;

    // sequencer and stack move decode
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = status_reg;
        mul_next    = mul_reg;
        ctrl_top    = '0;
        ctrl_rest   = '0;
        top_in      = value_reg;
        apply_pop   = 1'b0;
        div_start   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next  = S_RESULT;
                status_next = rse_pkg::ST_OK;
                unique case (cmd_reg)
                    rse_pkg::CMD_PUSH: begin
                        if (full) begin
                            status_next = rse_pkg::ST_OVER;
                        end else begin
                            ctrl_top.load_up  = 1'b1;
                            ctrl_rest.load_up = 1'b1;
                            count_next        = count_reg + CNT_W'(1);
                        end
                    end
                    rse_pkg::CMD_ADD: begin
                        if (few) begin
                            status_next = rse_pkg::ST_UNDER;
                        end else begin
                            top_in    = cell_data[1] + cell_data[0];
                            apply_pop = 1'b1;
                        end
                    end
                    rse_pkg::CMD_SUB: begin
                        if (few) begin
                            status_next = rse_pkg::ST_UNDER;
                        end else begin
                            top_in    = cell_data[1] - cell_data[0];
                            apply_pop = 1'b1;
                        end
                    end
                    rse_pkg::CMD_MUL: begin
                        if (few) begin
                            status_next = rse_pkg::ST_UNDER;
                        end else begin
                            mul_next   = cell_data[1] * cell_data[0];
                            state_next = S_MUL;
                        end
                    end
                    rse_pkg::CMD_DIV: begin
                        if (few) begin
                            status_next = rse_pkg::ST_UNDER;
                        end else if (cell_data[0] == '0) begin
                            status_next = rse_pkg::ST_DIVZERO;
                        end else begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_MUL: begin
                top_in     = mul_reg;
                apply_pop  = 1'b1;
                state_next = S_RESULT;
            end
            S_DIV: begin
                if (div_done) begin
                    top_in     = div_quot;
                    apply_pop  = 1'b1;
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        // operator result replaces the left operand, the rest moves up
        if (apply_pop) begin
            ctrl_top.load_up    = 1'b1;
            ctrl_rest.load_down = 1'b1;
            count_next          = count_reg - CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // token capture and working values
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg   <= s_tuser[rse_pkg::CMD_W-1:0];
            value_reg <= s_tdata;
        end
        status_reg <= status_next;
        mul_reg    <= mul_next;
    end

    // output register
    assign count_ext = (CNT_W + rse_pkg::DEPTH_W)'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_RESULT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_RESULT && out_free) begin
            m_top_reg    <= (count_reg != '0) ? cell_data[0] : '0;
            m_depth_reg  <= count_ext[rse_pkg::DEPTH_W-1:0];
            m_status_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_status_reg, m_depth_reg, m_top_reg};

    // stack cell chain, entry 0 on top
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [W-1:0]        up_d;
        logic [W-1:0]        down_d;
        rse_pkg::cell_ctrl_t ctrl_i;

        if (i == 0) begin : g_top
            assign up_d   = top_in;
            assign ctrl_i = ctrl_top;
        end else begin : g_mid
            assign up_d   = cell_data[i-1];
            assign ctrl_i = ctrl_rest;
        end

        if (i == STACK_DEPTH - 1) begin : g_last
            assign down_d = '0;
        end else begin : g_inner
            assign down_d = cell_data[i+1];
        end

        rse_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl_i),
            .up_data   (up_d),
            .down_data (down_d),
            .data      (cell_data[i])
        );
    end

    // divider
    rse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (cell_data[1]),
        .divisor  (cell_data[0]),
        .quotient (div_quot),
        .done     (div_done)
    );

endmodule
